[rtl/kscd_pkg.sv]
// shared constants, types and the key sequence table of the key sequence command decoder
package kscd_pkg;

    localparam int MAX_SEQUENCE_LEN = 6;
    localparam int TABLE_ENTRIES    = 36;
    localparam int COUNT_WIDTH      = 16;

    localparam int KEY_MAX   = 6;
    localparam int KEY_COUNT = 36;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ACTION_W = 5;
    localparam int REPEAT_W = 16;
    localparam int KLEN_W   = 3;

    localparam int LEN_W = $clog2(MAX_SEQUENCE_LEN + 1);
    localparam int IDX_W = (MAX_SEQUENCE_LEN > 1) ? $clog2(MAX_SEQUENCE_LEN) : 1;
    localparam int CMP_LEN    = (MAX_SEQUENCE_LEN < KEY_MAX) ? MAX_SEQUENCE_LEN : KEY_MAX;
    localparam int NUM_SEARCH = (TABLE_ENTRIES < KEY_COUNT) ? TABLE_ENTRIES : KEY_COUNT;
    localparam int CNT_EXT_W  = COUNT_WIDTH + 4;

    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;
    localparam int DEC_BASE = 10;

    typedef enum logic [STATUS_W-1:0] {
        ST_DIGIT   = 2'd0,
        ST_PENDING = 2'd1,
        ST_MATCH   = 2'd2,
        ST_DISCARD = 2'd3
    } status_t;

    typedef logic [MAX_SEQUENCE_LEN-1:0][BYTE_W-1:0] seq_buf_t;

    typedef struct packed {
        logic                hit;
        logic                pending;
        logic [ACTION_W-1:0] action;
    } match_t;

    localparam logic [KLEN_W-1:0] KEY_LEN [KEY_COUNT] = '{
        3'd1, 3'd2, 3'd6, 3'd1, 3'd2, 3'd1, 3'd6, 3'd2, 3'd3, 3'd2, 3'd2, 3'd1,
        3'd2, 3'd1, 3'd2, 3'd1, 3'd5, 3'd2, 3'd2, 3'd1, 3'd5, 3'd3, 3'd1, 3'd1,
        3'd3, 3'd1, 3'd1, 3'd3, 3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1
    };

    localparam logic [BYTE_W-1:0] KEY_BYTES [KEY_COUNT][KEY_MAX] = '{
        '{8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5B, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h5B, 8'h31, 8'h3B, 8'h32, 8'h43},
        '{8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5B, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h5B, 8'h31, 8'h3B, 8'h32, 8'h44},
        '{8'h5B, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h5B, 8'h42, 8'h00, 8'h00, 8'h00},
        '{8'h5B, 8'h48, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5B, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5B, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h79, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5B, 8'h31, 8'h3B, 8'h32, 8'h43, 8'h00},
        '{8'h64, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h79, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5B, 8'h31, 8'h3B, 8'h32, 8'h44, 8'h00},
        '{8'h1B, 8'h5B, 8'h46, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h5B, 8'h43, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h5B, 8'h41, 8'h00, 8'h00, 8'h00},
        '{8'h79, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h5B, 8'h48, 8'h00, 8'h00, 8'h00},
        '{8'h1B, 8'h5B, 8'h44, 8'h00, 8'h00, 8'h00},
        '{8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [ACTION_W-1:0] KEY_ACT [KEY_COUNT] = '{
        5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd2,  5'd16, 5'd17, 5'd18,
        5'd6,  5'd7,  5'd19, 5'd20, 5'd15, 5'd21, 5'd8,  5'd5,  5'd22, 5'd6,
        5'd23, 5'd9,  5'd11, 5'd24, 5'd2,  5'd25
    };

endpackage

[rtl/kscd_match.sv]
// parallel compare of the sequence buffer against the key table, first hit wins
module kscd_match
    import kscd_pkg::*;
(
    input  seq_buf_t         seq,
    input  logic [LEN_W-1:0] seq_len,
    output match_t           result
);

    logic [NUM_SEARCH-1:0] hit_vec;
    logic [NUM_SEARCH-1:0] short_vec;

    always_comb
    begin
        logic same;
        for (int e = 0; e < NUM_SEARCH; e++)
        begin
            same = (int'(seq_len) <= int'(KEY_LEN[e]));
            for (int k = 0; k < CMP_LEN; k++)
            begin
                if ((k < int'(seq_len)) && (seq[k] != KEY_BYTES[e][k]))
                begin
                    same = 1'b0;
                end
            end
            hit_vec[e]   = same;
            short_vec[e] = (int'(seq_len) < int'(KEY_LEN[e]));
        end
    end

    // priority select, lowest table index first
    always_comb
    begin
        result = '0;
        for (int e = NUM_SEARCH - 1; e >= 0; e--)
        begin
            if (hit_vec[e])
            begin
                result.hit     = 1'b1;
                result.pending = short_vec[e];
                result.action  = short_vec[e] ? '0 : KEY_ACT[e];
            end
        end
    end

endmodule

[rtl/key_sequence_command_decoder.sv]
// top level of the key sequence command decoder
// the result of a request is registered and valid in the cycle after it is accepted
// throughput: one request per cycle while no result is held or out_ready is high; the table compare and
//   the count update both finish in the single pass ahead of the result register
// reset clears the buffer length, the accumulated digit count and the result valid flag;
//   buffered bytes and the status, action and repeat_count registers are not cleared
module key_sequence_command_decoder
    import kscd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   key_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ACTION_W-1:0] action,
    output logic [REPEAT_W-1:0] repeat_count
);

    logic                   out_valid_reg;
    status_t                status_reg, status_next;
    logic [ACTION_W-1:0]    action_reg, action_next;
    logic [REPEAT_W-1:0]    repeat_reg, repeat_next;
    logic [LEN_W-1:0]       seq_len_reg, seq_len_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    seq_buf_t               seq_bytes_reg;
    seq_buf_t               seq_view;
    logic [LEN_W-1:0]       seq_len_inc;
    logic [CNT_EXT_W-1:0]   count_ext;
    logic [COUNT_WIDTH-1:0] count_sat;
    logic                   is_digit;
    logic                   buf_full;
    logic                   accept;
    logic                   append;
    match_t                 match;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign action    = action_reg;
    assign repeat_count = repeat_reg;

    assign is_digit    = key_byte inside {[DIGIT_ZERO:DIGIT_NINE]};
    assign buf_full    = (seq_len_reg >= LEN_W'(MAX_SEQUENCE_LEN));
    assign seq_len_inc = seq_len_reg + LEN_W'(1);
    assign append      = accept && !is_digit && !buf_full;

    // buffer as it stands with the new byte placed at the end
    always_comb
    begin
        for (int k = 0; k < MAX_SEQUENCE_LEN; k++)
        begin
            seq_view[k] = (LEN_W'(k) == seq_len_reg) ? key_byte : seq_bytes_reg[k];
        end
    end

    kscd_match u_match
    (
        .seq     (seq_view),
        .seq_len (seq_len_inc),
        .result  (match)
    );

    // count times ten plus digit, saturating
    assign count_ext = CNT_EXT_W'(count_reg) * CNT_EXT_W'(DEC_BASE)
                     + CNT_EXT_W'(key_byte - DIGIT_ZERO);
    assign count_sat = (count_ext[CNT_EXT_W-1:COUNT_WIDTH] != '0) ? '1
                     : count_ext[COUNT_WIDTH-1:0];

    always_comb
    begin
        status_next  = ST_DISCARD;
        action_next  = '0;
        repeat_next  = REPEAT_W'(count_reg);
        seq_len_next = '0;
        count_next   = '0;
        if (is_digit)
        begin
            status_next  = ST_DIGIT;
            repeat_next  = REPEAT_W'(count_sat);
            seq_len_next = seq_len_reg;
            count_next   = count_sat;
        end
        else if (!buf_full && match.hit)
        begin
            if (match.pending)
            begin
                status_next  = ST_PENDING;
                seq_len_next = seq_len_inc;
                count_next   = count_reg;
            end
            else
            begin
                status_next = ST_MATCH;
                action_next = match.action;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seq_len_reg   <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (accept)
            begin
                seq_len_reg <= seq_len_next;
                count_reg   <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            action_reg <= action_next;
            repeat_reg <= repeat_next;
        end
        if (append)
        begin
            seq_bytes_reg[seq_len_reg[IDX_W-1:0]] <= key_byte;
        end
    end

endmodule

[sim/tb_key_sequence_command_decoder.sv]
// testbench of the key sequence command decoder: predicted decodes checked against directed and random traffic
`timescale 1ns / 100ps
module tb_key_sequence_command_decoder;
    import kscd_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 10;
    localparam int ITEM_TARGET   = 1450;
    localparam int QUIET_TAIL    = 150;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 90;
    localparam int NUM_KEYS      = 36;
    localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH) - 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PASTE        = 5'd0,
        ACT_ARROW_DOWN   = 5'd1,
        ACT_WORD_END     = 5'd2,
        ACT_BACKSPACE    = 5'd3,
        ACT_ARROW_RIGHT  = 5'd4,
        ACT_UP           = 5'd5,
        ACT_WORD_BACK    = 5'd6,
        ACT_LINE_END     = 5'd7,
        ACT_DOWN         = 5'd8,
        ACT_LINE_START   = 5'd9,
        ACT_ARROW_LEFT   = 5'd10,
        ACT_LEFT         = 5'd11,
        ACT_ARROW_UP     = 5'd12,
        ACT_OPEN_ABOVE   = 5'd13,
        ACT_YANK_ALL     = 5'd14,
        ACT_RIGHT        = 5'd15,
        ACT_DELETE_LINE  = 5'd16,
        ACT_YANK_LINE    = 5'd17,
        ACT_END_OF_INPUT = 5'd18,
        ACT_PASTE_BEFORE = 5'd19,
        ACT_OPEN_BELOW   = 5'd20,
        ACT_INSERT       = 5'd21,
        ACT_YANK_DELETE  = 5'd22,
        ACT_GOTO_TOP     = 5'd23,
        ACT_ENTER        = 5'd24,
        ACT_GOTO_BOTTOM  = 5'd25
    } action_t;

    // key bytes right-justified, first byte in the highest used lane
    typedef struct packed {
        logic [2:0]          len;
        logic [47:0]         keys;
        logic [ACTION_W-1:0] act;
    } key_seq_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ACTION_W-1:0] action;
        logic [REPEAT_W-1:0] repeat_count;
    } decode_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   key_byte = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ACTION_W-1:0] action;
    logic [REPEAT_W-1:0] repeat_count;

    logic [BYTE_W-1:0] key_stream [$];
    decode_t           pending_decodes [$];

    logic [BYTE_W-1:0] held_bytes [MAX_SEQUENCE_LEN];
    int unsigned       held_len = 0;
    int unsigned       held_count = 0;

    int total_items    = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int errors         = 0;
    int cycle_count    = 0;

    int send_gap = 0, send_phase = 0;
    bit send_idling = 1'b1;
    int recv_gap = 0, recv_phase = 0;
    bit recv_idling = 1'b1;
    logic hold_active = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;

    key_sequence_command_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_byte     (key_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .action       (action),
        .repeat_count (repeat_count)
    );

    function automatic key_seq_t key_entry(int idx);
        key_seq_t e;
        e = '0;
        case (idx)
            0:  begin e.len = 1; e.keys = "p";             e.act = ACT_PASTE;        end
            1:  begin e.len = 2; e.keys = "[B";            e.act = ACT_ARROW_DOWN;   end
            2:  begin e.len = 6; e.keys = {8'h1B, "[1;2C"}; e.act = ACT_WORD_END;    end
            3:  begin e.len = 1; e.keys = 8'h7F;           e.act = ACT_BACKSPACE;    end
            4:  begin e.len = 2; e.keys = "[C";            e.act = ACT_ARROW_RIGHT;  end
            5:  begin e.len = 1; e.keys = "k";             e.act = ACT_UP;           end
            6:  begin e.len = 6; e.keys = {8'h1B, "[1;2D"}; e.act = ACT_WORD_BACK;   end
            7:  begin e.len = 2; e.keys = "[F";            e.act = ACT_LINE_END;     end
            8:  begin e.len = 3; e.keys = {8'h1B, "[B"};   e.act = ACT_DOWN;         end
            9:  begin e.len = 2; e.keys = "[H";            e.act = ACT_LINE_START;   end
            10: begin e.len = 2; e.keys = "[D";            e.act = ACT_ARROW_LEFT;   end
            11: begin e.len = 1; e.keys = "h";             e.act = ACT_LEFT;         end
            12: begin e.len = 2; e.keys = "[A";            e.act = ACT_ARROW_UP;     end
            13: begin e.len = 1; e.keys = "O";             e.act = ACT_OPEN_ABOVE;   end
            14: begin e.len = 2; e.keys = "ya";            e.act = ACT_YANK_ALL;     end
            15: begin e.len = 1; e.keys = "l";             e.act = ACT_RIGHT;        end
            16: begin e.len = 5; e.keys = "[1;2C";         e.act = ACT_WORD_END;     end
            17: begin e.len = 2; e.keys = "dd";            e.act = ACT_DELETE_LINE;  end
            18: begin e.len = 2; e.keys = "yy";            e.act = ACT_YANK_LINE;    end
            19: begin e.len = 1; e.keys = 8'h04;           e.act = ACT_END_OF_INPUT; end
            20: begin e.len = 5; e.keys = "[1;2D";         e.act = ACT_WORD_BACK;    end
            21: begin e.len = 3; e.keys = {8'h1B, "[F"};   e.act = ACT_LINE_END;     end
            22: begin e.len = 1; e.keys = "P";             e.act = ACT_PASTE_BEFORE; end
            23: begin e.len = 1; e.keys = "o";             e.act = ACT_OPEN_BELOW;   end
            24: begin e.len = 3; e.keys = {8'h1B, "[C"};   e.act = ACT_RIGHT;        end
            25: begin e.len = 1; e.keys = "i";             e.act = ACT_INSERT;       end
            26: begin e.len = 1; e.keys = "j";             e.act = ACT_DOWN;         end
            27: begin e.len = 3; e.keys = {8'h1B, "[A"};   e.act = ACT_UP;           end
            28: begin e.len = 2; e.keys = "yd";            e.act = ACT_YANK_DELETE;  end
            29: begin e.len = 1; e.keys = "b";             e.act = ACT_WORD_BACK;    end
            30: begin e.len = 2; e.keys = "gg";            e.act = ACT_GOTO_TOP;     end
            31: begin e.len = 3; e.keys = {8'h1B, "[H"};   e.act = ACT_LINE_START;   end
            32: begin e.len = 3; e.keys = {8'h1B, "[D"};   e.act = ACT_LEFT;         end
            33: begin e.len = 1; e.keys = 8'h0A;           e.act = ACT_ENTER;        end
            34: begin e.len = 1; e.keys = "e";             e.act = ACT_WORD_END;     end
            default: begin e.len = 1; e.keys = "G";        e.act = ACT_GOTO_BOTTOM;  end
        endcase
        return e;
    endfunction

    function automatic logic [BYTE_W-1:0] key_at(key_seq_t e, int k);
        return e.keys[(int'(e.len) - 1 - k) * 8 +: 8];
    endfunction

    // advances the decoder state by one byte and returns the decode it produces
    function automatic decode_t decode_key(logic [BYTE_W-1:0] kb);
        decode_t  r;
        key_seq_t e;
        bit       same;
        bit       found;
        r.status       = ST_DISCARD;
        r.action       = '0;
        r.repeat_count = held_count[REPEAT_W-1:0];
        found          = 1'b0;
        if (kb >= DIGIT_ZERO && kb <= DIGIT_NINE) begin
            held_count = held_count * DEC_BASE + int'(kb - DIGIT_ZERO);
            if (held_count > COUNT_MAX)
                held_count = COUNT_MAX;
            r.status       = ST_DIGIT;
            r.repeat_count = held_count[REPEAT_W-1:0];
            return r;
        end
        if (held_len >= MAX_SEQUENCE_LEN) begin
            held_len   = 0;
            held_count = 0;
            return r;
        end
        held_bytes[held_len] = kb;
        held_len++;
        for (int i = 0; i < TABLE_ENTRIES && i < NUM_KEYS && !found; i++) begin
            e    = key_entry(i);
            same = (held_len <= e.len);
            for (int k = 0; same && k < held_len; k++)
                if (held_bytes[k] != key_at(e, k))
                    same = 1'b0;
            if (same) begin
                found = 1'b1;
                if (held_len < e.len) begin
                    r.status = ST_PENDING;
                end else begin
                    r.status = ST_MATCH;
                    r.action = e.act;
                end
            end
        end
        if (r.status != ST_PENDING) begin
            held_len   = 0;
            held_count = 0;
        end
        return r;
    endfunction

    task automatic push_keys(int idx, int upto);
        key_seq_t e;
        e = key_entry(idx);
        for (int k = 0; k < upto && k < e.len; k++)
            key_stream.push_back(key_at(e, k));
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            key_stream.push_back(s[i]);
    endtask

    task automatic report(string field, int unsigned want, int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    // request side
    always @(posedge clk) begin
        bit quiet;
        if (!rst_n) begin
            in_valid <= 1'b0;
            key_byte <= '0;
        end else if (!in_valid || in_ready) begin
            quiet = !send_idling || hold_active || (items_accepted + QUIET_TAIL >= total_items);
            if (send_phase == 0) begin
                send_phase  = $urandom_range(40, 200);
                send_idling = !send_idling;
            end else begin
                send_phase--;
            end
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (key_stream.size() == 0) begin
                in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 14) - 1;
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                key_byte <= key_stream.pop_front();
            end
        end
    end

    // prediction on accepted requests, then check of accepted results
    always @(posedge clk) begin
        decode_t want;
        bit      quiet;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                pending_decodes.push_back(decode_key(key_byte));
                items_accepted++;
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_decodes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, status, action, repeat_count);
                    errors++;
                end else begin
                    want = pending_decodes.pop_front();
                    if (status !== want.status)
                        report("status", want.status, status);
                    if (action !== want.action)
                        report("action", want.action, action);
                    if (repeat_count !== want.repeat_count)
                        report("repeat_count", want.repeat_count, repeat_count);
                end
            end
            quiet = !recv_idling || (results_seen + QUIET_TAIL >= total_items);
            if (recv_phase == 0) begin
                recv_phase  = $urandom_range(40, 200);
                recv_idling = !recv_idling;
            end else begin
                recv_phase--;
            end
            if (hold_active) begin
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // one long back-pressure stretch so the request side fills up and stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_active <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            hold_active <= 1'b1;
        end else if (hold_active) begin
            hold_left--;
            if (hold_left == 0)
                hold_active <= 1'b0;
        end
    end

    initial begin
        rst_n = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int pick;
        int idx;
        int ndig;
        key_seq_t e;

        // directed: byte extremes, saturating count, digit inside an escape, control keys
        key_stream.push_back(8'h00);
        key_stream.push_back(8'hFF);
        push_text("70000G");
        push_text("12dd");
        key_stream.push_back(8'h1B);
        push_text("[1;2C");
        push_keys(31, 3);
        push_keys(1, 2);
        push_keys(3, 1);
        push_keys(19, 1);
        push_keys(33, 1);

        // random: mostly complete commands, some with a count prefix, some cut short, some noise
        while (key_stream.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 35) begin
                ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2);
                for (int i = 0; i < ndig; i++)
                    key_stream.push_back(DIGIT_ZERO + $urandom_range(0, 9));
            end
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, NUM_KEYS - 1);
            if (pick < 75) begin
                push_keys(idx, KEY_MAX);
            end else if (pick < 85) begin
                e = key_entry(idx);
                if (e.len > 1)
                    push_keys(idx, $urandom_range(1, e.len - 1));
                key_stream.push_back($urandom_range(0, 255));
            end else begin
                key_stream.push_back($urandom_range(0, 255));
            end
        end
        total_items = key_stream.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < total_items || pending_decodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && pending_decodes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/kscd_pkg.sv
rtl/kscd_match.sv
rtl/key_sequence_command_decoder.sv
sim/tb_key_sequence_command_decoder.sv
